// ===== src/smtg_pkg.sv =====
`timescale 1ns / 1ps

package smtg_pkg;

  // Security modes
  localparam logic [2:0] SM_VOID     = 3'd0;
  localparam logic [2:0] SM_CASUAL   = 3'd1;
  localparam logic [2:0] SM_SECURE   = 3'd2;
  localparam logic [2:0] SM_LOCKDOWN = 3'd3;
  localparam logic [2:0] SM_GHOST    = 3'd4;

  // Requester classes
  localparam logic [1:0] RQ_USER   = 2'd0;
  localparam logic [1:0] RQ_DAEMON = 2'd1;
  localparam logic [1:0] RQ_KERNEL = 2'd2;
  localparam logic [1:0] RQ_OTHER  = 2'd3;

  // Authorisation flag bit positions
  localparam int AUTH_PASS   = 0;
  localparam int AUTH_KEY    = 2;
  localparam int AUTH_COOL   = 3;
  localparam int AUTH_PROMPT = 4;
  localparam int AUTH_DEESC  = 5;
  localparam int AUTH_AUTO   = 6;
  localparam int AUTH_BOOT   = 7;

  // Result status
  localparam logic [1:0] ST_ACCEPTED = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_SAME     = 2'd2;

  // Reject reasons
  localparam logic [3:0] R_NONE   = 4'd0;
  localparam logic [3:0] R_TARGET = 4'd1;
  localparam logic [3:0] R_BOOT   = 4'd3;
  localparam logic [3:0] R_EDGE   = 4'd4;
  localparam logic [3:0] R_AUTH   = 4'd5;
  localparam logic [3:0] R_PROMPT = 4'd6;
  localparam logic [3:0] R_COOL   = 4'd7;
  localparam logic [3:0] R_KEY    = 4'd8;
  localparam logic [3:0] R_DEESC  = 4'd9;
  localparam logic [3:0] R_LIMIT  = 4'd10;

  // Configuration register indexes
  localparam logic [1:0] REG_SECURE_COOLDOWN = 2'd0;
  localparam logic [1:0] REG_DEESC_WINDOW    = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT     = 2'd2;

  // Register reset values
  localparam logic [15:0] SECURE_COOLDOWN_RST = 16'd2400;
  localparam logic [15:0] DEESC_WINDOW_RST    = 16'd300;
  localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd3;

  localparam int QUEUE_DEPTH_DEF = 2;

  // Classified request, as held in the queue
  typedef struct packed {
    logic [2:0]  tgt;
    logic        tgt_bad;
    logic        is_user;
    logic        is_daemon;
    logic        is_kernel;
    logic        ovr;
    logic [7:0]  auth;
    logic [63:0] tick;
  } req_t;

  // Configuration register set
  typedef struct packed {
    logic [15:0] secure_cooldown;
    logic [15:0] deesc_window;
    logic [3:0]  retry_limit;
  } cfg_t;

  // Default flag set for each requester class
  function automatic logic [7:0] dflt_auth(input logic [1:0] rq);
    logic [7:0] a;
    case (rq)
      RQ_USER:   a = 8'h0F;
      RQ_DAEMON: a = 8'h39;
      RQ_KERNEL: a = 8'hE8;
      RQ_OTHER:  a = 8'h00;
      default:   a = 8'h00;
    endcase
    return a;
  endfunction

endpackage

// ===== src/smtg_front.sv =====
`timescale 1ns / 1ps

module smtg_front import smtg_pkg::*; (
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_target,
  input  logic [1:0]  in_requester,
  input  logic [7:0]  in_auth_mask,
  input  logic        in_use_default_auth,
  input  logic [63:0] in_tick,
  input  logic        q_full,
  output logic        q_push,
  output req_t        q_data
);

  logic [7:0] auth;

  // Take a transaction whenever the queue has room
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Resolve the flag set and decode the requester
  always_comb begin
    auth = in_use_default_auth ? dflt_auth(in_requester) : in_auth_mask;
    q_data.tgt       = in_target;
    q_data.tgt_bad   = (in_target < SM_CASUAL) || (in_target > SM_GHOST);
    q_data.is_user   = in_requester == RQ_USER;
    q_data.is_daemon = in_requester == RQ_DAEMON;
    q_data.is_kernel = in_requester == RQ_KERNEL;
    q_data.ovr       = (in_requester == RQ_KERNEL) && auth[AUTH_AUTO];
    q_data.auth      = auth;
    q_data.tick      = in_tick;
  end

endmodule

// ===== src/smtg_queue.sv =====
`timescale 1ns / 1ps

module smtg_queue import smtg_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t push_data,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output req_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  req_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_pop;

  assign full       = cnt_r == CW'(DEPTH);
  assign head_valid = cnt_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== src/smtg_back.sv =====
`timescale 1ns / 1ps

module smtg_back import smtg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        q_valid,
  input  req_t        head,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_reason,
  output logic [2:0]  out_mode_now,
  output logic [2:0]  out_mode_before,
  output logic [4:0]  out_mode_onehot,
  output logic [63:0] out_epoch_now,
  output logic        out_reboot_request,
  output logic        out_persist_write,
  output logic [2:0]  out_persist_mode,
  output logic        out_tlb_flush
);

  // Mode state
  logic [2:0]  cur_r, cur_nxt;
  logic [2:0]  prev_r, prev_nxt;
  logic [4:0]  onehot_r, onehot_nxt;
  logic [63:0] ent_secure_r, ent_secure_nxt;
  logic [63:0] ent_lock_r, ent_lock_nxt;
  logic [3:0]  fail_cnt_r, fail_cnt_nxt;
  logic [63:0] epoch_r, epoch_nxt;

  // Result register
  logic        out_valid_r;
  logic [1:0]  status_r, status_nxt;
  logic [3:0]  reason_r, reason_nxt;
  logic        reboot_r, reboot_nxt;
  logic        pw_r, pw_nxt;
  logic [2:0]  pm_r, pm_nxt;
  logic        flush_r, flush_nxt;

  // Judgement
  logic [63:0] diff_cool, diff_deesc;
  logic        cool_short, deesc_short;
  logic [3:0]  fail_inc;
  logic [3:0]  judge_reason;
  logic        fail_bump, limit_hit;
  logic        u, d, k, ovr, pass;
  logic        judged, accept;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // Edge rules against the current mode
  always_comb begin
    u    = head.is_user;
    d    = head.is_daemon;
    k    = head.is_kernel;
    ovr  = head.ovr;
    pass = head.auth[AUTH_PASS];
    diff_cool   = head.tick - ent_secure_r;
    diff_deesc  = head.tick - ent_lock_r;
    cool_short  = diff_cool < {48'd0, cfg.secure_cooldown};
    deesc_short = diff_deesc < {48'd0, cfg.deesc_window};
    fail_inc    = (fail_cnt_r == 4'hF) ? 4'hF : fail_cnt_r + 4'd1;
    judge_reason = R_EDGE;
    fail_bump    = 1'b0;
    limit_hit    = 1'b0;
    case (cur_r)
      SM_VOID: begin
        if (head.tgt == SM_CASUAL) begin
          judge_reason = R_NONE;
        end else if (head.auth[AUTH_BOOT] &&
                     (head.tgt == SM_SECURE || head.tgt == SM_LOCKDOWN)) begin
          judge_reason = R_NONE;
        end else begin
          judge_reason = R_BOOT;
        end
      end
      SM_CASUAL: begin
        if (head.tgt == SM_SECURE) begin
          judge_reason = (u || d || k) ? R_NONE : R_EDGE;
        end else if (head.tgt == SM_LOCKDOWN) begin
          if (!(u || d || ovr)) begin
            judge_reason = R_EDGE;
          end else if (!pass && !ovr) begin
            judge_reason = R_AUTH;
            if (d) begin
              fail_bump = 1'b1;
              if (fail_inc >= cfg.retry_limit) begin
                limit_hit    = 1'b1;
                judge_reason = R_LIMIT;
              end
            end
          end else if (d && !head.auth[AUTH_PROMPT]) begin
            judge_reason = R_PROMPT;
          end else begin
            judge_reason = R_NONE;
          end
        end else if (head.tgt == SM_GHOST) begin
          if (!u) begin
            judge_reason = R_EDGE;
          end else begin
            judge_reason = pass ? R_NONE : R_AUTH;
          end
        end
      end
      SM_SECURE: begin
        if (head.tgt == SM_CASUAL) begin
          if (!(u || d || ovr)) begin
            judge_reason = R_EDGE;
          end else if (cool_short && !head.auth[AUTH_COOL]) begin
            judge_reason = R_COOL;
          end else begin
            judge_reason = (pass || ovr) ? R_NONE : R_AUTH;
          end
        end else if (head.tgt == SM_LOCKDOWN) begin
          if (!(u || d || ovr)) begin
            judge_reason = R_EDGE;
          end else begin
            judge_reason = (pass || ovr) ? R_NONE : R_AUTH;
          end
        end else if (head.tgt == SM_GHOST) begin
          judge_reason = (u || d || k) ? R_NONE : R_EDGE;
        end
      end
      SM_LOCKDOWN: begin
        if (head.tgt == SM_SECURE) begin
          if (!(u || d || ovr)) begin
            judge_reason = R_EDGE;
          end else if (u) begin
            judge_reason = head.auth[AUTH_KEY] ? R_NONE : R_KEY;
          end else if (deesc_short && !head.auth[AUTH_DEESC]) begin
            judge_reason = R_DEESC;
          end else if (!pass || !head.auth[AUTH_PROMPT]) begin
            judge_reason = ovr ? R_NONE : R_PROMPT;
          end else begin
            judge_reason = R_NONE;
          end
        end
      end
      SM_GHOST: begin
        if (head.tgt == SM_SECURE) begin
          if (!(u || ovr)) begin
            judge_reason = R_EDGE;
          end else begin
            judge_reason = (pass || ovr) ? R_NONE : R_AUTH;
          end
        end else if (head.tgt == SM_LOCKDOWN) begin
          judge_reason = (k || d) ? R_NONE : R_EDGE;
        end
      end
      default: judge_reason = R_EDGE;
    endcase
  end

  // Result and next state
  always_comb begin
    judged = (head.tgt != cur_r) && !head.tgt_bad;
    accept = judged && (judge_reason == R_NONE);
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    onehot_nxt     = onehot_r;
    ent_secure_nxt = ent_secure_r;
    ent_lock_nxt   = ent_lock_r;
    fail_cnt_nxt   = fail_cnt_r;
    epoch_nxt      = epoch_r;
    status_nxt     = ST_ACCEPTED;
    reason_nxt     = R_NONE;
    reboot_nxt     = 1'b0;
    pw_nxt         = 1'b0;
    pm_nxt         = SM_VOID;
    flush_nxt      = 1'b0;
    if (head.tgt == cur_r) begin
      status_nxt = ST_SAME;
    end else if (head.tgt_bad) begin
      status_nxt = ST_REJECTED;
      reason_nxt = R_TARGET;
    end else if (!accept) begin
      status_nxt = ST_REJECTED;
      reason_nxt = judge_reason;
      if (fail_bump) begin
        fail_cnt_nxt = fail_inc;
      end
      if (limit_hit) begin
        reboot_nxt = 1'b1;
        pw_nxt     = 1'b1;
        pm_nxt     = SM_LOCKDOWN;
      end
    end else begin
      prev_nxt   = cur_r;
      cur_nxt    = head.tgt;
      onehot_nxt = 5'(5'd1 << head.tgt);
      epoch_nxt  = epoch_r + 64'd1;
      flush_nxt  = (head.tgt == SM_GHOST) || (cur_r == SM_GHOST);
      if (head.tgt == SM_SECURE) begin
        ent_secure_nxt = head.tick;
      end
      if (head.tgt == SM_LOCKDOWN) begin
        ent_lock_nxt = head.tick;
        fail_cnt_nxt = 4'd0;
      end
      if (head.tgt != SM_GHOST) begin
        pw_nxt = 1'b1;
        pm_nxt = head.tgt;
      end
    end
  end

  // Control state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r        <= SM_VOID;
      prev_r       <= SM_VOID;
      onehot_r     <= '0;
      ent_secure_r <= '0;
      ent_lock_r   <= '0;
      fail_cnt_r   <= '0;
      epoch_r      <= 64'd1;
      out_valid_r  <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_r        <= cur_nxt;
        prev_r       <= prev_nxt;
        onehot_r     <= onehot_nxt;
        ent_secure_r <= ent_secure_nxt;
        ent_lock_r   <= ent_lock_nxt;
        fail_cnt_r   <= fail_cnt_nxt;
        epoch_r      <= epoch_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      status_r <= status_nxt;
      reason_r <= reason_nxt;
      reboot_r <= reboot_nxt;
      pw_r     <= pw_nxt;
      pm_r     <= pm_nxt;
      flush_r  <= flush_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_reason         = reason_r;
  assign out_mode_now       = cur_r;
  assign out_mode_before    = prev_r;
  assign out_mode_onehot    = onehot_r;
  assign out_epoch_now      = epoch_r;
  assign out_reboot_request = reboot_r;
  assign out_persist_write  = pw_r;
  assign out_persist_mode   = pm_r;
  assign out_tlb_flush      = flush_r;

endmodule

// ===== src/security_mode_transition_guard.sv =====
`timescale 1ns / 1ps

// Channel    Handshake           Payload
// in_        in_valid/in_ready   target, requester, auth_mask, use_default_auth, tick
// out_       out_valid/out_ready status, reason, mode_now/before/onehot, epoch_now, ...
// config     psel/penable/pwrite secure_cooldown @0, lockdown_deesc_window @4, retry_limit @8
//
// One transaction per cycle sustained while out_ready holds; between input and result lie
// the request queue and then the result register in the judging stage.
// The queue takes a transaction while a result waits, so up to QUEUE_DEPTH transactions
// can be held in the queue, beside the one in the result register, when the output stalls.
// Reset (rst_n, synchronous) puts the mode in void, the epoch at one and the registers
// at their defaults; no clearing pass is needed.
module security_mode_transition_guard import smtg_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_target,
  input  logic [1:0]  in_requester,
  input  logic [7:0]  in_auth_mask,
  input  logic        in_use_default_auth,
  input  logic [63:0] in_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [3:0]  out_reason,
  output logic [2:0]  out_mode_now,
  output logic [2:0]  out_mode_before,
  output logic [4:0]  out_mode_onehot,
  output logic [63:0] out_epoch_now,
  output logic        out_reboot_request,
  output logic        out_persist_write,
  output logic [2:0]  out_persist_mode,
  output logic        out_tlb_flush,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t       cfg_r;
  logic       cfg_wr;
  logic [1:0] cfg_idx;
  logic       q_full, q_push, q_pop, q_valid;
  req_t       q_data, q_head;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.secure_cooldown <= SECURE_COOLDOWN_RST;
      cfg_r.deesc_window    <= DEESC_WINDOW_RST;
      cfg_r.retry_limit     <= RETRY_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SECURE_COOLDOWN: cfg_r.secure_cooldown <= pwdata[15:0];
        REG_DEESC_WINDOW:    cfg_r.deesc_window    <= pwdata[15:0];
        REG_RETRY_LIMIT:     cfg_r.retry_limit     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (cfg_idx)
      REG_SECURE_COOLDOWN: prdata = {16'd0, cfg_r.secure_cooldown};
      REG_DEESC_WINDOW:    prdata = {16'd0, cfg_r.deesc_window};
      REG_RETRY_LIMIT:     prdata = {28'd0, cfg_r.retry_limit};
      default:             prdata = '0;
    endcase
  end

  smtg_front u_front (
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_target           (in_target),
    .in_requester        (in_requester),
    .in_auth_mask        (in_auth_mask),
    .in_use_default_auth (in_use_default_auth),
    .in_tick             (in_tick),
    .q_full              (q_full),
    .q_push              (q_push),
    .q_data              (q_data)
  );

  smtg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  smtg_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .q_valid            (q_valid),
    .head               (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_reason         (out_reason),
    .out_mode_now       (out_mode_now),
    .out_mode_before    (out_mode_before),
    .out_mode_onehot    (out_mode_onehot),
    .out_epoch_now      (out_epoch_now),
    .out_reboot_request (out_reboot_request),
    .out_persist_write  (out_persist_write),
    .out_persist_mode   (out_persist_mode),
    .out_tlb_flush      (out_tlb_flush)
  );

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top import smtg_pkg::*; ();

  // Expected or observed outcome of one transition request
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  reason;
    logic [2:0]  mode_now;
    logic [2:0]  mode_before;
    logic [4:0]  onehot;
    logic [63:0] epoch;
    logic        reboot;
    logic        persist_wr;
    logic [2:0]  persist_md;
    logic        flush;
  } guard_result_t;

  // Mode guard predictor plus queue of outcomes still owed by the block
  class mode_guard_scoreboard;
    logic [15:0]   cooldown;
    logic [15:0]   deesc_win;
    logic [3:0]    retry_lim;
    logic [2:0]    cur_mode;
    logic [2:0]    prior_mode;
    logic [4:0]    onehot;
    logic [63:0]   entered [5];
    logic [3:0]    fail_cnt;
    logic [63:0]   epoch;
    logic [7:0]    default_flags [4];
    guard_result_t pending_q [$];
    int            n_checked;
    int            n_accepted;
    int            n_reboots;
    int            n_errors;

    function new();
      default_flags = '{8'h0F, 8'h39, 8'hE8, 8'h00};
      cooldown   = SECURE_COOLDOWN_RST;
      deesc_win  = DEESC_WINDOW_RST;
      retry_lim  = RETRY_LIMIT_RST;
      cur_mode   = SM_VOID;
      prior_mode = SM_VOID;
      onehot     = '0;
      foreach (entered[i]) entered[i] = '0;
      fail_cnt   = '0;
      epoch      = 64'd1;
    endfunction

    // Register write; widths are masked and unknown indexes dropped
    function void write_reg(logic [1:0] idx, logic [31:0] v);
      case (idx)
        REG_SECURE_COOLDOWN: cooldown  = v[15:0];
        REG_DEESC_WINDOW:    deesc_win = v[15:0];
        REG_RETRY_LIMIT:     retry_lim = v[3:0];
        default: ;
      endcase
    endfunction

    // Edge and authorisation rules; R_NONE means the move is allowed
    function logic [3:0] judge(logic [2:0] cur, logic [2:0] tgt, logic [1:0] rq,
                               logic [7:0] a, logic [63:0] now, output bit hit);
      bit ovr;
      bit pass;
      bit u;
      bit d;
      bit k;
      ovr  = (rq == RQ_KERNEL) && a[AUTH_AUTO];
      pass = a[AUTH_PASS];
      u    = rq == RQ_USER;
      d    = rq == RQ_DAEMON;
      k    = rq == RQ_KERNEL;
      hit  = 1'b0;

      if (cur == SM_VOID) begin
        if (tgt == SM_CASUAL) return R_NONE;
        if (a[AUTH_BOOT] && (tgt == SM_SECURE || tgt == SM_LOCKDOWN)) return R_NONE;
        return R_BOOT;
      end
      if (cur == SM_CASUAL && tgt == SM_SECURE)
        return (u || d || k) ? R_NONE : R_EDGE;
      if (cur == SM_CASUAL && tgt == SM_LOCKDOWN) begin
        if (!(u || d || ovr)) return R_EDGE;
        if (!pass && !ovr) begin
          // failed daemon password attempts count towards a reboot
          if (d) begin
            if (fail_cnt != 4'hF) fail_cnt++;
            if (fail_cnt >= retry_lim) begin
              hit = 1'b1;
              return R_LIMIT;
            end
          end
          return R_AUTH;
        end
        if (d && !a[AUTH_PROMPT]) return R_PROMPT;
        return R_NONE;
      end
      if (cur == SM_CASUAL && tgt == SM_GHOST) begin
        if (!u) return R_EDGE;
        return pass ? R_NONE : R_AUTH;
      end
      if (cur == SM_SECURE && tgt == SM_CASUAL) begin
        if (!(u || d || ovr)) return R_EDGE;
        if ((now - entered[SM_SECURE]) < {48'd0, cooldown} && !a[AUTH_COOL]) return R_COOL;
        return (pass || ovr) ? R_NONE : R_AUTH;
      end
      if (cur == SM_SECURE && tgt == SM_LOCKDOWN) begin
        if (!(u || d || ovr)) return R_EDGE;
        return (pass || ovr) ? R_NONE : R_AUTH;
      end
      if (cur == SM_SECURE && tgt == SM_GHOST)
        return (u || d || k) ? R_NONE : R_EDGE;
      if (cur == SM_LOCKDOWN && tgt == SM_SECURE) begin
        if (!(u || d || ovr)) return R_EDGE;
        if (u) return a[AUTH_KEY] ? R_NONE : R_KEY;
        if ((now - entered[SM_LOCKDOWN]) < {48'd0, deesc_win} && !a[AUTH_DEESC])
          return R_DEESC;
        if (!pass || !a[AUTH_PROMPT]) return ovr ? R_NONE : R_PROMPT;
        return R_NONE;
      end
      if (cur == SM_GHOST && tgt == SM_SECURE) begin
        if (!(u || ovr)) return R_EDGE;
        return (pass || ovr) ? R_NONE : R_AUTH;
      end
      if (cur == SM_GHOST && tgt == SM_LOCKDOWN)
        return (k || d) ? R_NONE : R_EDGE;
      return R_EDGE;
    endfunction

    // Accepted request transaction: update state and queue the outcome
    function void note_request(logic [2:0] tgt, logic [1:0] rq, logic [7:0] auth,
                               logic use_dflt, logic [63:0] now);
      guard_result_t r;
      logic [7:0]    a;
      logic [3:0]    why;
      logic [2:0]    from;
      bit            hit;
      r = '0;
      a = use_dflt ? default_flags[rq] : auth;
      if (tgt == cur_mode) begin
        r.status = ST_SAME;
      end else if (tgt < SM_CASUAL || tgt > SM_GHOST) begin
        r.status = ST_REJECTED;
        r.reason = R_TARGET;
      end else begin
        why = judge(cur_mode, tgt, rq, a, now, hit);
        if (why != R_NONE) begin
          r.status = ST_REJECTED;
          r.reason = why;
          if (hit) begin
            r.reboot     = 1'b1;
            r.persist_wr = 1'b1;
            r.persist_md = SM_LOCKDOWN;
            n_reboots++;
          end
        end else begin
          from         = cur_mode;
          r.status     = ST_ACCEPTED;
          prior_mode   = from;
          cur_mode     = tgt;
          onehot       = 5'b00001 << tgt;
          entered[tgt] = now;
          if (tgt == SM_LOCKDOWN) fail_cnt = '0;
          epoch        = epoch + 64'd1;
          r.flush      = (tgt == SM_GHOST) || (from == SM_GHOST);
          if (tgt <= SM_LOCKDOWN) begin
            r.persist_wr = 1'b1;
            r.persist_md = tgt;
          end
          n_accepted++;
        end
      end
      r.mode_now    = cur_mode;
      r.mode_before = prior_mode;
      r.onehot      = onehot;
      r.epoch       = epoch;
      pending_q.push_back(r);
    endfunction

    function void cmp_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        n_errors++;
        if (n_errors <= 50)
          $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    // Result transaction: compare against the oldest outstanding outcome
    function void check_result(guard_result_t got);
      guard_result_t want;
      if (pending_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with no request outstanding, actual %0h", $time, got);
        return;
      end
      want = pending_q.pop_front();
      n_checked++;
      cmp_field("status",         64'(want.status),      64'(got.status));
      cmp_field("reason",         64'(want.reason),      64'(got.reason));
      cmp_field("mode_now",       64'(want.mode_now),    64'(got.mode_now));
      cmp_field("mode_before",    64'(want.mode_before), 64'(got.mode_before));
      cmp_field("mode_onehot",    64'(want.onehot),      64'(got.onehot));
      cmp_field("epoch_now",      want.epoch,            got.epoch);
      cmp_field("reboot_request", 64'(want.reboot),      64'(got.reboot));
      cmp_field("persist_write",  64'(want.persist_wr),  64'(got.persist_wr));
      cmp_field("persist_mode",   64'(want.persist_md),  64'(got.persist_md));
      cmp_field("tlb_flush",      64'(want.flush),       64'(got.flush));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_target = '0;
  logic [1:0]  in_requester = '0;
  logic [7:0]  in_auth_mask = '0;
  logic        in_use_default_auth = 1'b0;
  logic [63:0] in_tick = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [3:0]  out_reason;
  logic [2:0]  out_mode_now;
  logic [2:0]  out_mode_before;
  logic [4:0]  out_mode_onehot;
  logic [63:0] out_epoch_now;
  logic        out_reboot_request;
  logic        out_persist_write;
  logic [2:0]  out_persist_mode;
  logic        out_tlb_flush;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  mode_guard_scoreboard sb;
  bit          in_idle_on;
  bit          out_idle_on;
  int          stall_left;
  int          n_sent;
  logic [63:0] clock_tick;

  security_mode_transition_guard dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Gap length: mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Transaction monitors, sampled at the rising edge
  always @(posedge clk) begin
    guard_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(in_target, in_requester, in_auth_mask,
                        in_use_default_auth, in_tick);
      if (out_valid && out_ready) begin
        got.status      = out_status;
        got.reason      = out_reason;
        got.mode_now    = out_mode_now;
        got.mode_before = out_mode_before;
        got.onehot      = out_mode_onehot;
        got.epoch       = out_epoch_now;
        got.reboot      = out_reboot_request;
        got.persist_wr  = out_persist_write;
        got.persist_md  = out_persist_mode;
        got.flush       = out_tlb_flush;
        sb.check_result(got);
      end
    end
  end

  // Result-side back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (out_idle_on && $urandom_range(0, 99) < 30) begin
      out_ready <= 1'b0;
      stall_left = gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Drive one request and hold it until taken; returns at a falling edge
  task automatic send_request(logic [2:0] tgt, logic [1:0] rq, logic [7:0] auth,
                              logic use_dflt, logic [63:0] now);
    in_valid            <= 1'b1;
    in_target           <= tgt;
    in_requester        <= rq;
    in_auth_mask        <= auth;
    in_use_default_auth <= use_dflt;
    in_tick             <= now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    n_sent++;
    if (in_idle_on && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      repeat (gap_len()) @(negedge clk);
    end
  endtask

  // Random request, mostly along edges that lead out of the current mode
  task automatic send_random();
    logic [2:0] tgt;
    logic [7:0] auth;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      tgt = 3'($urandom_range(0, 7));
    end else if (r < 25) begin
      tgt = 3'($urandom_range(SM_CASUAL, SM_GHOST));
    end else begin
      case (sb.cur_mode)
        SM_VOID:     tgt = 3'($urandom_range(SM_CASUAL, SM_LOCKDOWN));
        SM_CASUAL:   tgt = 3'($urandom_range(SM_SECURE, SM_GHOST));
        SM_SECURE:   tgt = $urandom_range(0, 1) ? SM_CASUAL :
                           ($urandom_range(0, 1) ? SM_LOCKDOWN : SM_GHOST);
        SM_LOCKDOWN: tgt = SM_SECURE;
        default:     tgt = $urandom_range(0, 1) ? SM_SECURE : SM_LOCKDOWN;
      endcase
    end
    auth = 8'($urandom_range(0, 255));
    // password, key and prompt together, often enough to get transitions through
    if ($urandom_range(0, 1)) auth = auth | 8'h15;
    r = $urandom_range(0, 99);
    if (r < 3) clock_tick = {$urandom(), $urandom()};
    else if (r < 10) clock_tick = clock_tick + 64'($urandom_range(1000, 70000));
    else clock_tick = clock_tick + 64'($urandom_range(0, 60));
    send_request(tgt, 2'($urandom_range(0, 3)), auth, $urandom_range(0, 99) < 25, clock_tick);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic cfg_write(logic [3:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.write_reg(addr[3:2], data);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Let every outstanding result come back, then allow for the pipeline
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(logic [31:0] cool, logic [31:0] win, logic [31:0] lim,
                           bit idle_on);
    settle();
    cfg_write({REG_SECURE_COOLDOWN, 2'b00}, cool);
    cfg_write({REG_DEESC_WINDOW, 2'b00}, win);
    cfg_write({REG_RETRY_LIMIT, 2'b00}, lim);
    in_idle_on  = idle_on;
    out_idle_on = idle_on;
    repeat (140) send_random();
  endtask

  // Overall timeout
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [63:0] wrap_tick;
    sb          = new();
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
    wrap_tick   = 64'hFFFF_FFFF_FFFF_FFF0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed walk through the edges at reset register values
    send_request(SM_VOID,     RQ_USER,   8'h00, 1'b0, 64'd0);
    send_request(3'd7,        RQ_OTHER,  8'hFF, 1'b1, '1);
    send_request(SM_GHOST,    RQ_USER,   8'hFF, 1'b0, 64'd1);
    send_request(SM_SECURE,   RQ_USER,   8'h7F, 1'b0, 64'd2);
    send_request(SM_LOCKDOWN, RQ_KERNEL, 8'h80, 1'b0, 64'd3);
    send_request(SM_SECURE,   RQ_DAEMON, 8'h00, 1'b1, wrap_tick);
    send_request(SM_CASUAL,   RQ_OTHER,  8'hFF, 1'b0, wrap_tick + 64'd4);
    // tick has wrapped past zero: still inside the cooldown
    send_request(SM_CASUAL,   RQ_USER,   8'h01, 1'b0, 64'd5);
    send_request(SM_CASUAL,   RQ_USER,   8'h00, 1'b1, 64'd6);
    // daemon without password until the retry limit trips
    send_request(SM_LOCKDOWN, RQ_DAEMON, 8'h00, 1'b0, 64'd7);
    send_request(SM_LOCKDOWN, RQ_DAEMON, 8'h00, 1'b0, 64'd8);
    send_request(SM_LOCKDOWN, RQ_DAEMON, 8'h00, 1'b0, 64'd9);
    send_request(SM_LOCKDOWN, RQ_DAEMON, 8'h01, 1'b0, 64'd10);
    send_request(SM_GHOST,    RQ_USER,   8'hFE, 1'b0, 64'd12);
    send_request(SM_GHOST,    RQ_USER,   8'h01, 1'b0, 64'd13);
    send_request(SM_CASUAL,   RQ_USER,   8'hFF, 1'b0, 64'd14);
    send_request(SM_SECURE,   RQ_KERNEL, 8'h40, 1'b0, 64'd15);
    send_request(SM_LOCKDOWN, RQ_OTHER,  8'hFF, 1'b0, 64'd16);
    send_request(SM_LOCKDOWN, RQ_USER,   8'h01, 1'b0, 64'd17);
    send_request(SM_SECURE,   RQ_USER,   8'h00, 1'b0, 64'd18);
    send_request(SM_SECURE,   RQ_KERNEL, 8'h00, 1'b0, 64'd19);
    send_request(SM_SECURE,   RQ_DAEMON, 8'h01, 1'b0, 64'd20);
    send_request(SM_SECURE,   RQ_KERNEL, 8'h40, 1'b0, 64'd400);
    send_request(SM_GHOST,    RQ_KERNEL, 8'h00, 1'b0, 64'd401);
    send_request(SM_LOCKDOWN, RQ_USER,   8'hFF, 1'b0, 64'd402);
    send_request(SM_LOCKDOWN, RQ_KERNEL, 8'h00, 1'b0, 64'd404);

    // Random phases over several register settings
    clock_tick = 64'd1000;
    run_phase(32'd0, 32'd0, 32'd1, 1'b1);
    run_phase(32'd65535, 32'd65535, 32'd15, 1'b0);
    // upper bits set: only the low bits reach the registers; limit of zero
    settle();
    cfg_write(4'd12, 32'hFFFF_FFFF);
    run_phase(32'hABCD_0014, 32'h1234_0032, 32'h0000_00F0, 1'b1);
    run_phase(32'd300, 32'd10, 32'd5, 1'b1);
    run_phase(32'd2400, 32'd300, 32'd3, 1'b1);
    settle();

    $display("Run: %0d requests, %0d results checked, %0d mode changes, %0d reboot requests",
             n_sent, sb.n_checked, sb.n_accepted, sb.n_reboots);
    $display("Settings: reset, minimum, maximum, masked and mid-range, with and without stalls");
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/smtg_pkg.sv
src/smtg_front.sv
src/smtg_queue.sv
src/smtg_back.sv
src/security_mode_transition_guard.sv
test/tb_top.sv
